// ===== design/strict_base64_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// strict_base64_decoder_assert.svh
// Assertion macros shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef STRICT_BASE64_DECODER_ASSERT_SVH
`define STRICT_BASE64_DECODER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SB64_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SB64_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sb64_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb64_pkg
// Types, codes and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
package sb64_pkg;

	typedef enum logic [1:0] {
		CLS_ALPHA = 2'd0,
		CLS_PAD   = 2'd1,
		CLS_BAD   = 2'd2
	} char_cls_t;

	typedef struct packed {
		char_cls_t  cls;
		logic [5:0] sextet;
		logic       last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	localparam int QDEPTH = 2;
	localparam int QCNT_W = 2;
	localparam int QPTR_W = 1;

	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_CHAR   = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;
	localparam logic [1:0] ERR_PAD    = 2'd3;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;

	function automatic q_entry_t classify(input logic [7:0] c, input logic last);
		q_entry_t   e;
		logic [7:0] v;
		e.cls    = CLS_ALPHA;
		e.last   = last;
		v        = 8'd0;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			v = c - CH_UPPER_A;
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
			v = c - CH_LOWER_A + 8'd26;
		end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
			v = c - CH_DIGIT_0 + 8'd52;
		end else if (c == CH_PLUS) begin
			v = 8'd62;
		end else if (c == CH_SLASH) begin
			v = 8'd63;
		end else if (c == CH_EQUALS) begin
			e.cls = CLS_PAD;
		end else begin
			e.cls = CLS_BAD;
		end
		e.sextet = v[5:0];
		return e;
	endfunction

endpackage

// ===== design/sb64_text_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb64_text_if
// Input channel: one base64 character per transfer.
// ----------------------------------------------------------------------------
interface sb64_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       last_char;

	modport source (output valid, output in_char, output last_char, input ready);
	modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

// ===== design/sb64_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb64_result_if
// Output channel: one decode result per transfer.
// ----------------------------------------------------------------------------
interface sb64_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       message_done;
	logic [1:0] error_code;

	modport source (output valid, output data_byte, output byte_valid,
		output message_done, output error_code, input ready);
	modport sink   (input valid, input data_byte, input byte_valid,
		input message_done, input error_code, output ready);
endinterface

// ===== design/sb64_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb64_front
// Accepts characters and classifies them into queue entries.
// ----------------------------------------------------------------------------
module sb64_front (
	sb64_text_if.sink         text,
	input  sb64_pkg::q_stat_t q_stat,
	output logic              push,
	output sb64_pkg::q_entry_t entry
);
	import sb64_pkg::*;

	assign text.ready = !q_stat.full;
	assign push       = text.valid && !q_stat.full;
	assign entry      = classify(text.in_char, text.last_char);
endmodule

// ===== design/sb64_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb64_queue
// Two-entry queue between the classifier and the decode engine.
// ----------------------------------------------------------------------------
module sb64_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sb64_pkg::q_entry_t wr_entry,
	input  logic               pop,
	output sb64_pkg::q_entry_t rd_entry,
	output sb64_pkg::q_stat_t  q_stat
);
	import sb64_pkg::*;

	q_entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	assign rd_entry     = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
endmodule

// ===== design/sb64_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sb64_back
// Decode engine: bit buffer, character, padding and length checks, result register.
// ----------------------------------------------------------------------------
module sb64_back (
	input  logic               clk,
	input  logic               arst_n,
	input  sb64_pkg::q_stat_t  q_stat,
	input  sb64_pkg::q_entry_t entry,
	output logic               pop,
	sb64_result_if.source      result
);
	import sb64_pkg::*;

	// leftover bit count is kept in pairs of bits: 0, 2, 4 or 6
	logic [5:0] lbits_q,  lbits_n;
	logic [1:0] lpairs_q, lpairs_n;
	logic [1:0] pad_q,    pad_n;
	logic [1:0] cmf_q,    cmf_n;
	logic [1:0] bm3_q,    bm3_n;
	logic       cerr_q,   cerr_n;

	logic       out_valid_q;
	logic [7:0] data_q,   byte_n;
	logic       bv_q,     bv_n;
	logic       done_q;
	logic [1:0] err_q,    err_n;
	logic [1:0] need;

	assign pop = !q_stat.empty && (!out_valid_q || result.ready);

	always_comb begin
		lbits_n  = lbits_q;
		lpairs_n = lpairs_q;
		pad_n    = pad_q;
		bm3_n    = bm3_q;
		cerr_n   = cerr_q;
		cmf_n    = cmf_q + 2'd1;
		byte_n   = 8'd0;
		bv_n     = 1'b0;
		err_n    = ERR_NONE;
		need     = 2'd0;

		if (!cerr_q) begin
			unique case (entry.cls)
				CLS_PAD: begin
					if (pad_q != 2'd3) pad_n = pad_q + 2'd1;
				end
				CLS_ALPHA: begin
					if (pad_q != 2'd0) begin
						cerr_n = 1'b1;
					end else begin
						unique case (lpairs_q)
							2'd0: begin
								lbits_n  = entry.sextet;
								lpairs_n = 2'd3;
							end
							2'd1: begin
								byte_n   = {lbits_q[1:0], entry.sextet};
								lbits_n  = 6'd0;
								lpairs_n = 2'd0;
							end
							2'd2: begin
								byte_n   = {lbits_q[3:0], entry.sextet[5:2]};
								lbits_n  = {4'd0, entry.sextet[1:0]};
								lpairs_n = 2'd1;
							end
							2'd3: begin
								byte_n   = {lbits_q, entry.sextet[5:4]};
								lbits_n  = {2'd0, entry.sextet[3:0]};
								lpairs_n = 2'd2;
							end
						endcase
						if (lpairs_q != 2'd0) begin
							bv_n  = 1'b1;
							bm3_n = (bm3_q >= 2'd2) ? 2'd0 : bm3_q + 2'd1;
						end
					end
				end
				default: cerr_n = 1'b1;
			endcase
		end

		if (entry.last) begin
			unique case (bm3_n)
				2'd1:    need = 2'd2;
				2'd2:    need = 2'd1;
				default: need = 2'd0;
			endcase
			priority if (cmf_n != 2'd0) begin
				err_n = ERR_LENGTH;
			end else if (cerr_n) begin
				err_n = ERR_CHAR;
			end else if (pad_n == 2'd3 || pad_n != need || lbits_n != 6'd0) begin
				err_n = ERR_PAD;
			end else begin
				err_n = ERR_NONE;
			end
			lbits_n  = 6'd0;
			lpairs_n = 2'd0;
			pad_n    = 2'd0;
			cmf_n    = 2'd0;
			bm3_n    = 2'd0;
			cerr_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbits_q     <= '0;
			lpairs_q    <= '0;
			pad_q       <= '0;
			cmf_q       <= '0;
			bm3_q       <= '0;
			cerr_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				lbits_q  <= lbits_n;
				lpairs_q <= lpairs_n;
				pad_q    <= pad_n;
				cmf_q    <= cmf_n;
				bm3_q    <= bm3_n;
				cerr_q   <= cerr_n;
			end
			if (pop)               out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= byte_n;
			bv_q   <= bv_n;
			done_q <= entry.last;
			err_q  <= err_n;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.data_byte    = data_q;
	assign result.byte_valid   = bv_q;
	assign result.message_done = done_q;
	assign result.error_code   = err_q;
endmodule

// ===== design/strict_base64_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_base64_decoder
// Streaming strict base64 decoder, one character in, one result out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  text     in   in_char[7:0], last_char                          valid/ready
//  result   out  data_byte[7:0], byte_valid, message_done,
//                error_code[1:0]                                   valid/ready
//
//  One character per cycle sustained while results are taken; a text transfer
//  is written into the queue and then into the result register (classifier
//  into a two-entry queue, then the decode engine with its result register).
//  Reset clears the queue, the decode state and the result valid flag.
//  A stalled result holds the engine; the queue keeps taking characters
//  until both entries are full.
// ----------------------------------------------------------------------------
`include "strict_base64_decoder_assert.svh"

module strict_base64_decoder (
	input  logic          clk,
	input  logic          arst_n,
	sb64_text_if.sink     text,
	sb64_result_if.source result
);
	import sb64_pkg::*;

	q_stat_t  q_stat;
	q_entry_t wr_entry;
	q_entry_t rd_entry;
	logic     push;
	logic     pop;

	sb64_front u_front (
		.text   (text),
		.q_stat (q_stat),
		.push   (push),
		.entry  (wr_entry)
	);

	sb64_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.q_stat   (q_stat)
	);

	sb64_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.entry  (rd_entry),
		.pop    (pop),
		.result (result)
	);

	`SB64_ASSERT_IMP(a_no_push_full, push, !q_stat.full, "push into full queue")
	`SB64_ASSERT_IMP(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
	`SB64_ASSERT_IMP(a_err_only_done, result.valid && !result.message_done,
		result.error_code == ERR_NONE, "error code outside message end")
	`SB64_ASSERT_NXT(a_pop_gives_result, pop, result.valid, "popped entry gave no result")
endmodule
